@@ rtl/ctq_pkg.sv @@
// Package for the collision table query block: request opcodes, queue item
// type, back-end state type and the sine table used by the rotation math.
// No dependencies.
package ctq_pkg;

   localparam int MaxObjectsDefault = 16;
   localparam int QueueDepth        = 2;
   localparam int Degrees           = 360;

   typedef enum logic [1:0] {
      OP_WR_LOC   = 2'd0,
      OP_WR_SHAPE = 2'd1,
      OP_TICK     = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_CUBE     = 3'd0,
      KIND_CYLINDER = 3'd1,
      KIND_SPHERE   = 3'd2,
      KIND_DISK     = 3'd3,
      KIND_SQUARE   = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      B_IDLE, B_EXEC, B_TICK, B_SCAN, B_MUL1, B_SUM1, B_MUL2, B_SUM2, B_TEST, B_DONE
   } back_state_type;

   typedef struct packed {
      op_type             op;
      logic [3:0]         entry_index;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [2:0]         kind;
      logic               check;
      logic [8:0]         angle_x;
      logic [8:0]         angle_y;
      logic signed [9:0]  spin_x;
      logic signed [9:0]  spin_y;
      logic [30:0]        margin;
   } item_type;

   localparam logic signed [15:0] QuarterSine [91] = '{
      16'sd0, 16'sd286, 16'sd572, 16'sd857, 16'sd1143, 16'sd1428, 16'sd1713, 16'sd1997,
      16'sd2280, 16'sd2563, 16'sd2845, 16'sd3126, 16'sd3406, 16'sd3686, 16'sd3964,
      16'sd4240, 16'sd4516, 16'sd4790, 16'sd5063, 16'sd5334, 16'sd5604, 16'sd5872,
      16'sd6138, 16'sd6402, 16'sd6664, 16'sd6924, 16'sd7182, 16'sd7438, 16'sd7692,
      16'sd7943, 16'sd8192, 16'sd8438, 16'sd8682, 16'sd8923, 16'sd9162, 16'sd9397,
      16'sd9630, 16'sd9860, 16'sd10087, 16'sd10311, 16'sd10531, 16'sd10749, 16'sd10963,
      16'sd11174, 16'sd11381, 16'sd11585, 16'sd11786, 16'sd11982, 16'sd12176, 16'sd12365,
      16'sd12551, 16'sd12733, 16'sd12911, 16'sd13085, 16'sd13255, 16'sd13421, 16'sd13583,
      16'sd13741, 16'sd13894, 16'sd14044, 16'sd14189, 16'sd14330, 16'sd14466, 16'sd14598,
      16'sd14726, 16'sd14849, 16'sd14968, 16'sd15082, 16'sd15191, 16'sd15296, 16'sd15396,
      16'sd15491, 16'sd15582, 16'sd15668, 16'sd15749, 16'sd15826, 16'sd15897, 16'sd15964,
      16'sd16026, 16'sd16083, 16'sd16135, 16'sd16182, 16'sd16225, 16'sd16262, 16'sd16294,
      16'sd16321, 16'sd16343, 16'sd16362, 16'sd16374, 16'sd16382, 16'sd16384
   };

   // Sine in Q1.14 of an angle in whole degrees, 0 to 359.
   function automatic logic signed [15:0] sine_q14(input logic [8:0] d);
      logic [8:0] k;
      logic       neg;
      begin
         neg = 1'b0;
         if (d <= 9'd90) begin
            k = d;
         end else if (d <= 9'd180) begin
            k = 9'd180 - d;
         end else if (d <= 9'd270) begin
            k = d - 9'd180;
            neg = 1'b1;
         end else begin
            k = 9'd360 - d;
            neg = 1'b1;
         end
         sine_q14 = neg ? -QuarterSine[k[6:0]] : QuarterSine[k[6:0]];
      end
   endfunction

   function automatic logic signed [15:0] cosine_q14(input logic [8:0] d);
      logic [9:0] t;
      begin
         t = {1'b0, d} + 10'd90;
         if (t >= 10'd360) begin
            t = t - 10'd360;
         end
         cosine_q14 = sine_q14(t[8:0]);
      end
   endfunction

   // Angle of the inverse rotation, kept in 0 to 359.
   function automatic logic [8:0] negate_angle(input logic [8:0] a);
      negate_angle = (a == 9'd0) ? 9'd0 : 9'd360 - a;
   endfunction

   // Angle plus spin, reduced into 0 to 359.
   function automatic logic [8:0] wrap_add(input logic [8:0] a, input logic signed [9:0] st);
      logic signed [11:0] t;
      begin
         t = signed'({3'b000, a}) + 12'(st) + 12'sd720;
         for (int k = 0; k < 4; k++) begin
            if (t >= 12'sd360) begin
               t = t - 12'sd360;
            end
         end
         wrap_add = t[8:0];
      end
   endfunction

endpackage

@@ rtl/ctq_if.sv @@
// Channel interfaces for the collision table query block: request channel
// and response channel, each with valid/ready handshake. No dependencies.
interface ctq_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [3:0]         entry_index;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   logic signed [31:0] coord_z;
   logic [2:0]         kind;
   logic               check_flag;
   logic [8:0]         angle_x;
   logic [8:0]         angle_y;
   logic signed [9:0]  spin_x;
   logic signed [9:0]  spin_y;
   logic [30:0]        margin;

   modport source (output valid, req_type, entry_index, coord_x, coord_y, coord_z, kind,
                   check_flag, angle_x, angle_y, spin_x, spin_y, margin, input ready);
   modport sink (input valid, req_type, entry_index, coord_x, coord_y, coord_z, kind,
                 check_flag, angle_x, angle_y, spin_x, spin_y, margin, output ready);
endinterface

interface ctq_rsp_if;
   logic       valid;
   logic       ready;
   logic       hit;
   logic [3:0] hit_index;
   logic       rotation_changed;

   modport source (output valid, hit, hit_index, rotation_changed, input ready);
   modport sink (input valid, hit, hit_index, rotation_changed, output ready);
endinterface

@@ rtl/ctq_front.sv @@
// Front end: accepts request transactions and decodes them into queue items.
// Depends on ctq_pkg and ctq_if.
module ctq_front (
   ctq_req_if.sink            req_bus,
   input  logic               queue_full,
   output logic               push,
   output ctq_pkg::item_type  push_item
);
   import ctq_pkg::*;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   always_comb begin
      push_item.op          = op_type'(req_bus.req_type);
      push_item.entry_index = req_bus.entry_index;
      push_item.x           = req_bus.coord_x;
      push_item.y           = req_bus.coord_y;
      push_item.z           = req_bus.coord_z;
      push_item.kind        = req_bus.kind;
      push_item.check       = req_bus.check_flag;
      // Written angles are stored reduced to one turn.
      push_item.angle_x     = (req_bus.angle_x >= 9'd360) ? req_bus.angle_x - 9'd360
                                                          : req_bus.angle_x;
      push_item.angle_y     = (req_bus.angle_y >= 9'd360) ? req_bus.angle_y - 9'd360
                                                          : req_bus.angle_y;
      push_item.spin_x      = req_bus.spin_x;
      push_item.spin_y      = req_bus.spin_y;
      push_item.margin      = req_bus.margin;
   end
endmodule

@@ rtl/ctq_queue.sv @@
// Short FIFO between the front end and the back end.
// Depends on ctq_pkg.
module ctq_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ctq_pkg::item_type  push_item,
   input  logic               pop,
   output ctq_pkg::item_type  pop_item,
   output logic               empty,
   output logic               full
);
   import ctq_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   item_type          slot_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CntW'(QueueDepth));
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full && !pop |=> count_ff == CntW'(QueueDepth))
      else $error("queue overflowed");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue popped while empty");
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QueueDepth))
      else $error("queue count out of range");
`endif
endmodule

@@ rtl/ctq_back.sv @@
// Back end: object table, tick and query sequencer with the rotation
// datapath, and the response register. Depends on ctq_pkg and ctq_if.
module ctq_back #(
   parameter int MAX_OBJECTS = ctq_pkg::MaxObjectsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [4:0]         object_count,
   input  logic               queue_empty,
   input  ctq_pkg::item_type  queue_item,
   output logic               pop,
   ctq_rsp_if.source          rsp_bus
);
   import ctq_pkg::*;

   localparam int IdxW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam int CntW = $clog2(MAX_OBJECTS + 1);

   // Object table.
   logic [2:0]         kind_ff   [MAX_OBJECTS];
   logic               check_ff  [MAX_OBJECTS];
   logic signed [31:0] loc_x_ff  [MAX_OBJECTS];
   logic signed [31:0] loc_y_ff  [MAX_OBJECTS];
   logic signed [31:0] loc_z_ff  [MAX_OBJECTS];
   logic signed [31:0] ext_x_ff  [MAX_OBJECTS];
   logic signed [31:0] ext_y_ff  [MAX_OBJECTS];
   logic signed [31:0] ext_z_ff  [MAX_OBJECTS];
   logic [8:0]         rot_x_ff  [MAX_OBJECTS];
   logic [8:0]         rot_y_ff  [MAX_OBJECTS];
   logic signed [9:0]  step_x_ff [MAX_OBJECTS];
   logic signed [9:0]  step_y_ff [MAX_OBJECTS];

   back_state_type     state_ff, state_in;
   item_type           item_ff;
   logic [CntW-1:0]    scan_ff;
   logic [CntW-1:0]    limit;
   logic [IdxW-1:0]    sel;
   logic [IdxW-1:0]    wr_addr;
   logic               wr_ok;
   logic               scan_done;
   logic               eligible;
   logic               box_hit;
   logic               load_rsp;
   logic               hit_ff;
   logic               changed_ff;

   logic signed [32:0] ax_ff, ay_ff, az_ff;
   logic signed [15:0] s_ff, c_ff;
   logic [8:0]         rx_ff;
   logic signed [48:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [49:0] sum1, sum2;
   logic signed [35:0] bx_ff, by_ff, bz_ff;
   logic signed [51:0] q1_ff, q2_ff, q3_ff, q4_ff;
   logic signed [52:0] sum3, sum4;
   logic signed [38:0] fx_ff, fy_ff, fz_ff;
   logic signed [40:0] mg;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [3:0]         rsp_index_ff;
   logic               rsp_changed_ff;

   assign limit     = (32'(object_count) > MAX_OBJECTS) ? CntW'(MAX_OBJECTS)
                                                        : CntW'(object_count);
   assign sel       = scan_ff[IdxW-1:0];
   assign wr_addr   = IdxW'(item_ff.entry_index);
   assign wr_ok     = (32'(item_ff.entry_index) < MAX_OBJECTS);
   assign scan_done = (scan_ff >= limit);
   assign eligible  = check_ff[sel] && (kind_ff[sel] <= KIND_SPHERE);
   assign mg        = 41'(signed'({1'b0, item_ff.margin}));

   // Box test in the entry frame: -margin <= a <= extent + margin on every axis.
   always_comb begin
      box_hit = (41'(fx_ff) + mg >= 41'sd0) && (41'(fx_ff) - mg <= 41'(ext_x_ff[sel])) &&
                (41'(fy_ff) + mg >= 41'sd0) && (41'(fy_ff) - mg <= 41'(ext_y_ff[sel])) &&
                (41'(fz_ff) + mg >= 41'sd0) && (41'(fz_ff) - mg <= 41'(ext_z_ff[sel]));
   end

   assign sum1 = 50'(p1_ff) + 50'(p2_ff) + 50'sd8192;
   assign sum2 = 50'(p3_ff) - 50'(p4_ff) + 50'sd8192;
   assign sum3 = 53'(q1_ff) - 53'(q2_ff) + 53'sd8192;
   assign sum4 = 53'(q3_ff) + 53'(q4_ff) + 53'sd8192;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!queue_empty) state_in = B_EXEC;
         end
         B_EXEC: begin
            unique case (item_ff.op)
               OP_WR_LOC, OP_WR_SHAPE: state_in = B_DONE;
               OP_TICK:                state_in = B_TICK;
               OP_QUERY:               state_in = B_SCAN;
               default:                state_in = B_DONE;
            endcase
         end
         B_TICK: begin
            if (scan_done) state_in = B_DONE;
         end
         B_SCAN: begin
            if (scan_done) begin
               state_in = B_DONE;
            end else if (eligible) begin
               state_in = B_MUL1;
            end
         end
         B_MUL1: state_in = B_SUM1;
         B_SUM1: state_in = B_MUL2;
         B_MUL2: state_in = B_SUM2;
         B_SUM2: state_in = B_TEST;
         B_TEST: state_in = box_hit ? B_DONE : B_SCAN;
         B_DONE: begin
            if (load_rsp) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      pop      = (state_ff == B_IDLE) && !queue_empty;
      load_rsp = (state_ff == B_DONE) && (!rsp_valid_ff || rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff    <= queue_item;
         scan_ff    <= '0;
         hit_ff     <= 1'b0;
         changed_ff <= 1'b0;
      end
      if (state_ff == B_EXEC && wr_ok) begin
         if (item_ff.op == OP_WR_LOC) begin
            loc_x_ff[wr_addr] <= item_ff.x;
            loc_y_ff[wr_addr] <= item_ff.y;
            loc_z_ff[wr_addr] <= item_ff.z;
         end else if (item_ff.op == OP_WR_SHAPE) begin
            ext_x_ff[wr_addr]  <= item_ff.x;
            ext_y_ff[wr_addr]  <= item_ff.y;
            ext_z_ff[wr_addr]  <= item_ff.z;
            kind_ff[wr_addr]   <= item_ff.kind;
            check_ff[wr_addr]  <= item_ff.check;
            rot_x_ff[wr_addr]  <= item_ff.angle_x;
            rot_y_ff[wr_addr]  <= item_ff.angle_y;
            step_x_ff[wr_addr] <= item_ff.spin_x;
            step_y_ff[wr_addr] <= item_ff.spin_y;
         end
      end
      if (state_ff == B_TICK && !scan_done) begin
         if (step_x_ff[sel] != 10'sd0) begin
            rot_x_ff[sel] <= wrap_add(rot_x_ff[sel], step_x_ff[sel]);
            changed_ff    <= 1'b1;
         end
         if (step_y_ff[sel] != 10'sd0) begin
            rot_y_ff[sel] <= wrap_add(rot_y_ff[sel], step_y_ff[sel]);
            changed_ff    <= 1'b1;
         end
         scan_ff <= scan_ff + 1'b1;
      end
      if (state_ff == B_SCAN && !scan_done) begin
         ax_ff <= 33'(item_ff.x) - 33'(loc_x_ff[sel]);
         ay_ff <= 33'(item_ff.y) - 33'(loc_y_ff[sel]);
         az_ff <= 33'(item_ff.z) - 33'(loc_z_ff[sel]);
         // Spheres take the same path with both angles at zero.
         if (kind_ff[sel] == KIND_SPHERE) begin
            s_ff  <= sine_q14(9'd0);
            c_ff  <= cosine_q14(9'd0);
            rx_ff <= 9'd0;
         end else begin
            s_ff  <= sine_q14(negate_angle(rot_y_ff[sel]));
            c_ff  <= cosine_q14(negate_angle(rot_y_ff[sel]));
            rx_ff <= negate_angle(rot_x_ff[sel]);
         end
         if (!eligible) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
      if (state_ff == B_MUL1) begin
         p1_ff <= az_ff * s_ff;
         p2_ff <= ax_ff * c_ff;
         p3_ff <= az_ff * c_ff;
         p4_ff <= ax_ff * s_ff;
      end
      if (state_ff == B_SUM1) begin
         bx_ff <= 36'(sum1 >>> 14);
         bz_ff <= 36'(sum2 >>> 14);
         by_ff <= 36'(ay_ff);
         s_ff  <= sine_q14(rx_ff);
         c_ff  <= cosine_q14(rx_ff);
      end
      if (state_ff == B_MUL2) begin
         q1_ff <= by_ff * c_ff;
         q2_ff <= bz_ff * s_ff;
         q3_ff <= by_ff * s_ff;
         q4_ff <= bz_ff * c_ff;
      end
      if (state_ff == B_SUM2) begin
         fx_ff <= 39'(bx_ff);
         fy_ff <= 39'(sum3 >>> 14);
         fz_ff <= 39'(sum4 >>> 14);
      end
      if (state_ff == B_TEST) begin
         if (box_hit) begin
            hit_ff <= 1'b1;
         end else begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
      if (load_rsp) begin
         rsp_hit_ff     <= hit_ff;
         rsp_index_ff   <= hit_ff ? 4'(sel) : 4'd0;
         rsp_changed_ff <= changed_ff;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.hit              = rsp_hit_ff;
   assign rsp_bus.hit_index        = rsp_index_ff;
   assign rsp_bus.rotation_changed = rsp_changed_ff;

`ifndef SYNTH
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == B_EXEC)
      else $error("item popped outside idle");
   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_TICK || state_ff == B_SCAN) |-> scan_ff <= limit)
      else $error("scan index past the object count");
   a_hit_not_tick: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> !(rsp_hit_ff && rsp_changed_ff))
      else $error("response reports both a hit and a rotation change");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff && $stable(rsp_index_ff))
      else $error("response dropped while stalled");
`endif
endmodule

@@ rtl/collision_table_query.sv @@
// Collision table query: requests write table entries, tick the rotations,
// or query a point with a margin against the table. A front end decodes
// requests into a two-entry queue, and a back end sequences each item one at
// a time. A tick adds the spin to the angles of every entry below
// object_count. A query skips entries that are unchecked or not a cube,
// cylinder or sphere and passes each other entry through the two-pass
// rotate datapath (multiply, then round and sum, per rotation), stopping
// at the first hit. Each request gives one response.
module collision_table_query #(
   parameter int MAX_OBJECTS = ctq_pkg::MaxObjectsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data,
   ctq_req_if.sink    req_bus,
   ctq_rsp_if.source  rsp_bus
);
   import ctq_pkg::*;

   logic [4:0] object_count_ff;
   logic       push;
   logic       pop;
   logic       queue_empty;
   logic       queue_full;
   item_type   push_item;
   item_type   queue_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         object_count_ff <= 5'd0;
      end else if (csr_wr_en) begin
         object_count_ff <= csr_wr_data;
      end
   end

   ctq_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   ctq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (queue_item),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   ctq_back #(.MAX_OBJECTS(MAX_OBJECTS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .object_count (object_count_ff),
      .queue_empty  (queue_empty),
      .queue_item   (queue_item),
      .pop          (pop),
      .rsp_bus      (rsp_bus)
   );
endmodule

@@ sim/collision_table_query_tb.sv @@
// Testbench for the collision table query block: drives writes, ticks and
// point queries and checks each response against an in-bench table model.
// Depends on rtl/ctq_pkg.sv, rtl/ctq_if.sv and rtl/collision_table_query.sv.
class ctq_scoreboard;
   typedef struct {
      logic       hit;
      logic [3:0] hit_index;
      logic       rotation_changed;
   } rsp_type;

   int unsigned       live_count;
   logic [2:0]        kind_tab  [16];
   logic              check_tab [16];
   logic signed [31:0] lx [16], ly [16], lz [16], ex [16], ey [16], ez [16];
   int                ang_x [16], ang_y [16], spn_x [16], spn_y [16];
   rsp_type           pending[$];
   int                mismatches;
   int                checked;
   int                hits;

   function new();
      live_count = 0;
      mismatches = 0;
      checked = 0;
      hits = 0;
      for (int i = 0; i < 16; i++) begin
         kind_tab[i] = 0; check_tab[i] = 0;
         lx[i] = 0; ly[i] = 0; lz[i] = 0; ex[i] = 0; ey[i] = 0; ez[i] = 0;
         ang_x[i] = 0; ang_y[i] = 0; spn_x[i] = 0; spn_y[i] = 0;
      end
   endfunction

   function int sine_deg(int d);
      int q;
      int k;
      q = ((d % 360) + 360) % 360;
      k = (q <= 90) ? q : (q <= 180) ? 180 - q : (q <= 270) ? q - 180 : 360 - q;
      return (q > 180) ? -int'(ctq_pkg::QuarterSine[k]) : int'(ctq_pkg::QuarterSine[k]);
   endfunction

   function longint rnd14(longint v);
      return (v + 8192) >>> 14;
   endfunction

   function bit inside_box(int i, longint ax, longint ay, longint az, longint mg);
      return ax + mg >= 0 && ax - mg <= ex[i] && ay + mg >= 0 && ay - mg <= ey[i] &&
             az + mg >= 0 && az - mg <= ez[i];
   endfunction

   function bit entry_collides(int i, longint px, longint py, longint pz, longint mg);
      longint ax, ay, az, bx, by, bz, s, c;
      int ry, rx;
      ax = px - lx[i]; ay = py - ly[i]; az = pz - lz[i];
      if (kind_tab[i] == ctq_pkg::KIND_SPHERE) return inside_box(i, ax, ay, az, mg);
      if (kind_tab[i] > ctq_pkg::KIND_CYLINDER) return 0;
      ry = (360 - ang_y[i]) % 360;
      s = sine_deg(ry); c = sine_deg(ry + 90);
      bx = rnd14(az * s + ax * c);
      by = ay;
      bz = rnd14(az * c - ax * s);
      rx = (360 - ang_x[i]) % 360;
      s = sine_deg(rx); c = sine_deg(rx + 90);
      return inside_box(i, bx, rnd14(by * c - bz * s), rnd14(by * s + bz * c), mg);
   endfunction

   function void note_request(ctq_pkg::item_type it);
      rsp_type r;
      int n;
      r = '{0, 0, 0};
      n = (live_count > 16) ? 16 : live_count;
      case (it.op)
         ctq_pkg::OP_WR_LOC: begin
            lx[it.entry_index] = it.x; ly[it.entry_index] = it.y; lz[it.entry_index] = it.z;
         end
         ctq_pkg::OP_WR_SHAPE: begin
            ex[it.entry_index] = it.x; ey[it.entry_index] = it.y; ez[it.entry_index] = it.z;
            kind_tab[it.entry_index] = it.kind;
            check_tab[it.entry_index] = it.check;
            ang_x[it.entry_index] = it.angle_x % 360;
            ang_y[it.entry_index] = it.angle_y % 360;
            spn_x[it.entry_index] = it.spin_x;
            spn_y[it.entry_index] = it.spin_y;
         end
         ctq_pkg::OP_TICK: begin
            for (int i = 0; i < n; i++) begin
               if (spn_x[i] != 0) begin
                  r.rotation_changed = 1'b1;
                  ang_x[i] = ((ang_x[i] + spn_x[i]) % 360 + 360) % 360;
               end
               if (spn_y[i] != 0) begin
                  r.rotation_changed = 1'b1;
                  ang_y[i] = ((ang_y[i] + spn_y[i]) % 360 + 360) % 360;
               end
            end
         end
         default: begin
            for (int i = 0; i < n; i++) begin
               if (check_tab[i] && entry_collides(i, it.x, it.y, it.z, longint'(it.margin))) begin
                  r.hit = 1'b1;
                  r.hit_index = 4'(i);
                  hits++;
                  break;
               end
            end
         end
      endcase
      pending.push_back(r);
   endfunction

   function void check_response(logic hit, logic [3:0] idx, logic chg);
      rsp_type e;
      checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: response with nothing pending");
         return;
      end
      e = pending.pop_front();
      if (e.hit !== hit || e.hit_index !== idx || e.rotation_changed !== chg) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: exp hit=%0d idx=%0d chg=%0d, got hit=%0d idx=%0d chg=%0d",
                     e.hit, e.hit_index, e.rotation_changed, hit, idx, chg);
      end
   endfunction
endclass

module collision_table_query_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ctq_pkg::*;

   localparam int WatchdogLimit = 20000;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [4:0] csr_wr_data;
   logic       rsp_stall_en;
   logic       rsp_hold;
   logic       quiet;
   int         idle_cycles;
   int         sent;
   ctq_scoreboard board;

   ctq_req_if req_bus ();
   ctq_rsp_if rsp_bus ();

   collision_table_query u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus.sink),
      .rsp_bus     (rsp_bus.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: random stalls in bursts, plus one long hold-off on request.
   initial begin
      int burst;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
            rsp_hold = 1'b0;
         end else if (rsp_stall_en && !quiet && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 4);
            rsp_bus.ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_response(rsp_bus.hit, rsp_bus.hit_index, rsp_bus.rotation_changed);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send(item_type it);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= it.op;
      req_bus.entry_index <= it.entry_index;
      req_bus.coord_x     <= it.x;
      req_bus.coord_y     <= it.y;
      req_bus.coord_z     <= it.z;
      req_bus.kind        <= it.kind;
      req_bus.check_flag  <= it.check;
      req_bus.angle_x     <= it.angle_x;
      req_bus.angle_y     <= it.angle_y;
      req_bus.spin_x      <= it.spin_x;
      req_bus.spin_y      <= it.spin_y;
      req_bus.margin      <= it.margin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_request(it);
      sent++;
   endtask

   task automatic go_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_count(int unsigned n);
      go_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 5'(n);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.live_count = n;
      @(posedge clock);
   endtask

   function automatic item_type blank(op_type op);
      item_type it;
      it = '0;
      it.op = op;
      return it;
   endfunction

   function automatic logic signed [31:0] near_coord();
      return $urandom_range(0, 7) == 0 ? $urandom
                                        : 32'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
   endfunction

   function automatic item_type rand_loc(int i);
      item_type it;
      it = blank(OP_WR_LOC);
      it.entry_index = 4'(i);
      it.x = near_coord(); it.y = near_coord(); it.z = near_coord();
      return it;
   endfunction

   function automatic item_type rand_shape(int i);
      item_type it;
      it = blank(OP_WR_SHAPE);
      it.entry_index = 4'(i);
      it.x = $urandom_range(0, 8) == 0 ? $urandom : $urandom_range(0, 12 << 16);
      it.y = $urandom_range(0, 8) == 0 ? $urandom : $urandom_range(0, 12 << 16);
      it.z = $urandom_range(0, 8) == 0 ? $urandom : $urandom_range(0, 12 << 16);
      it.kind = 3'($urandom_range(0, 9) < 6 ? $urandom_range(0, 2) : $urandom_range(0, 7));
      it.check = $urandom_range(0, 4) != 0;
      it.angle_x = 9'($urandom_range(0, 359));
      it.angle_y = 9'($urandom_range(0, 359));
      it.spin_x = 10'($urandom_range(0, 2) == 0 ? 0 : int'($urandom_range(0, 718)) - 359);
      it.spin_y = 10'($urandom_range(0, 2) == 0 ? 0 : int'($urandom_range(0, 718)) - 359);
      return it;
   endfunction

   function automatic item_type rand_query();
      item_type it;
      it = blank(OP_QUERY);
      it.x = near_coord(); it.y = near_coord(); it.z = near_coord();
      it.margin = 31'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 4 << 16));
      it.entry_index = 4'($urandom);
      return it;
   endfunction

   task automatic fill_table();
      for (int i = 0; i < 16; i++) begin
         send(rand_loc(i));
         send(rand_shape(i));
      end
   endtask

   initial begin
      item_type it;
      int unsigned counts[6];
      counts = '{16, 0, 1, 31, 7, 16};
      board = new();
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      rsp_stall_en = 1'b0;
      rsp_hold = 1'b0;
      quiet = 1'b0;
      sent = 0;
      idle_cycles = 0;
      req_bus.valid <= 1'b0;
      req_bus.req_type <= OP_WR_LOC;
      req_bus.entry_index <= '0;
      req_bus.coord_x <= '0; req_bus.coord_y <= '0; req_bus.coord_z <= '0;
      req_bus.kind <= '0; req_bus.check_flag <= 1'b0;
      req_bus.angle_x <= '0; req_bus.angle_y <= '0;
      req_bus.spin_x <= '0; req_bus.spin_y <= '0; req_bus.margin <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: queries and ticks on an empty table, then extreme values.
      send(blank(OP_QUERY));
      send(blank(OP_TICK));
      it = blank(OP_WR_LOC); it.x = 32'h8000_0000; it.y = 32'h7fff_ffff; it.z = '0;
      send(it);
      it = blank(OP_WR_SHAPE); it.x = 32'h7fff_ffff; it.y = 32'h7fff_ffff;
      it.z = 32'h7fff_ffff; it.kind = KIND_CUBE; it.check = 1'b1;
      it.angle_x = 9'd511; it.angle_y = 9'd359; it.spin_x = -10'sd359; it.spin_y = 10'sd359;
      send(it);
      for (int k = 1; k < 16; k++) begin
         it = blank(OP_WR_LOC); it.entry_index = 4'(k); send(it);
         it = blank(OP_WR_SHAPE); it.entry_index = 4'(k); it.kind = 3'(k);
         it.check = 1'b1; it.x = 1 << 16; it.y = 1 << 16; it.z = 1 << 16;
         it.angle_x = 9'h100 | 9'(k); it.spin_x = (k == 3) ? 10'sd360 : 10'sd0;
         send(it);
      end
      set_count(16);
      it = blank(OP_QUERY); it.margin = 31'h7fff_ffff; it.x = 32'h8000_0000; send(it);
      it = blank(OP_QUERY); it.x = 32'h7fff_ffff; it.y = 32'h8000_0000; send(it);
      send(blank(OP_TICK));
      it = blank(OP_QUERY); it.x = 1 << 15; it.y = 1 << 15; it.z = 1 << 15; send(it);

      // Random phases across several counts.
      rsp_stall_en = 1'b1;
      foreach (counts[p]) begin
         set_count(counts[p]);
         fill_table();
         if (p == 1) begin
            rsp_hold = 1'b1;
            repeat (20) send(rand_query());
         end
         if (p == 2) go_idle();
         if (p == 5) quiet = 1'b1;
         repeat (110) begin
            case ($urandom_range(0, 9))
               0: send(rand_loc($urandom_range(0, 15)));
               1: send(rand_shape($urandom_range(0, 15)));
               2: send(blank(OP_TICK));
               default: send(rand_query());
            endcase
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses, %0d query hits.",
               sent, board.checked, board.hits);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
